### sv/tkf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tkf_pkg;

  typedef enum logic [3:0] {
    OP_ANGLE,
    OP_P00,
    OP_P01P10,
    OP_P11,
    OP_C11,
    OP_C10,
    OP_C01,
    OP_C00,
    OP_ANG_CORR,
    OP_BIAS_CORR
  } op_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_wb;
    logic div_start;
    logic div_wb;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic out_full;
  } sts_t;

  typedef struct packed {
    logic [31:0] qa;
    logic [31:0] qg;
    logic [31:0] r;
    logic [31:0] dt;
  } cfg_t;

  localparam logic [1:0] REG_QA = 2'd0;
  localparam logic [1:0] REG_QG = 2'd1;
  localparam logic [1:0] REG_R  = 2'd2;
  localparam logic [1:0] REG_DT = 2'd3;

  localparam logic [31:0] QA_RESET = 32'd4294967;
  localparam logic [31:0] QG_RESET = 32'd4294967;
  localparam logic [31:0] R_RESET  = 32'd327680;
  localparam logic [31:0] DT_RESET = 32'd17179869;

  localparam logic signed [47:0] ONE_Q32 = 48'sh0001_0000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] s;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      s = 32'sh7fff_ffff;
    end else if (v < 64'shffff_ffff_8000_0000) begin
      s = 32'sh8000_0000;
    end else begin
      s = v[31:0];
    end
    return s;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] s;
    if (v > 64'sh0000_7fff_ffff_ffff) begin
      s = 48'sh7fff_ffff_ffff;
    end else if (v < 64'shffff_8000_0000_0000) begin
      s = 48'sh8000_0000_0000;
    end else begin
      s = v[47:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### sv/tilt_kalman_filter.sv
// An accepted input beat runs through ten multiplications and the 80-step
// divider before out_valid rises. One item is taken at a time; an untaken
// result beat holds the following item back before its result is loaded.
// Reset (synchronous, active high) restores the registers to their defaults,
// clears angle and bias and sets the covariance to the identity.
`timescale 1ns / 1ps
`default_nettype none
module tilt_kalman_filter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] angle_meas,
  input  wire logic signed [31:0] gyro_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      angle_est,
  output logic signed [31:0]      rate_est
);
  import tkf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.qa <= QA_RESET;
      cfg.qg <= QG_RESET;
      cfg.r  <= R_RESET;
      cfg.dt <= DT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_QA: cfg.qa <= pwdata;
        REG_QG: cfg.qg <= pwdata;
        REG_R:  cfg.r  <= pwdata;
        REG_DT: cfg.dt <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_QA:  prdata = cfg.qa;
      REG_QG:  prdata = cfg.qg;
      REG_R:   prdata = cfg.r;
      REG_DT:  prdata = cfg.dt;
      default: prdata = 32'd0;
    endcase
  end

  tkf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tkf_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .angle_meas (angle_meas),
    .gyro_rate  (gyro_rate),
    .angle_est  (angle_est),
    .rate_est   (rate_est),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule
`default_nettype wire

### sv/tkf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module tkf_mul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [50:0] a,
  input  wire logic signed [50:0] b,
  output logic                    done,
  output logic signed [63:0]      res
);
  logic [50:0] ma, mb;
  logic [17:0] ah, bh;
  logic [31:0] al, bl;
  logic [31:0] opx, opy;
  logic        neg, cap, busy;
  logic [2:0]  ph;
  logic [63:0] prod, acc, rmag;

  assign ma = a[50] ? -a : a;
  assign mb = b[50] ? -b : b;

  always_comb begin
    case (ph)
      3'd0: begin
        opx = 32'(ah);
        opy = 32'(bh);
      end
      3'd1: begin
        opx = 32'(ah);
        opy = bl;
      end
      3'd2: begin
        opx = al;
        opy = 32'(bh);
      end
      default: begin
        opx = al;
        opy = bl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg  <= a[50] ^ b[50];
        ah   <= ma[49:32];
        al   <= ma[31:0];
        bh   <= mb[49:32];
        bl   <= mb[31:0];
        acc  <= 64'd0;
        cap  <= 1'b0;
        ph   <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (ph <= 3'd3) begin
          prod <= opx * opy;
        end
        case (ph) inside
          3'd1: begin
            if (prod >= 64'h0000_0000_4000_0000) begin
              cap <= 1'b1;
            end
            acc <= acc + {prod[31:0], 32'd0};
          end
          3'd2, 3'd3: begin
            acc <= acc + prod;
          end
          3'd4: begin
            acc  <= acc + (prod >> 32);
            busy <= 1'b0;
            done <= 1'b1;
          end
          default: begin
          end
        endcase
        ph <= ph + 3'd1;
      end
    end
  end

  assign rmag = (cap || acc > 64'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : acc;
  assign res  = neg ? -signed'(rmag) : signed'(rmag);

endmodule
`default_nettype wire

### sv/tkf_div.sv
`timescale 1ns / 1ps
`default_nettype none
module tkf_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] den,
  input  wire logic signed [47:0] num0,
  input  wire logic signed [47:0] num1,
  output logic                    done,
  output logic signed [47:0]      k0,
  output logic signed [47:0]      k1
);
  logic [63:0] dmag;
  logic [50:0] dm;
  logic        zero, busy;
  logic [6:0]  cnt;
  logic [47:0] nm   [2];
  logic [47:0] nsh  [2];
  logic [50:0] r    [2];
  logic [51:0] rs   [2];
  logic [51:0] rsub [2];
  logic        ge   [2];
  logic [46:0] q    [2];
  logic        over [2];
  logic        neg  [2];
  logic signed [47:0] kv [2];

  assign dmag = den[63] ? -den : den;
  assign nm[0] = num0[47] ? -num0 : num0;
  assign nm[1] = num1[47] ? -num1 : num1;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rs[l]   = {r[l], nsh[l][47]};
      rsub[l] = rs[l] - {1'b0, dm};
      ge[l]   = rs[l] >= {1'b0, dm};
      if (zero) begin
        kv[l] = 48'sd0;
      end else if (over[l] && !neg[l]) begin
        kv[l] = 48'sh7fff_ffff_ffff;
      end else if (over[l]) begin
        kv[l] = 48'sh8000_0000_0000;
      end else if (neg[l]) begin
        kv[l] = -signed'({1'b0, q[l]});
      end else begin
        kv[l] = signed'({1'b0, q[l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd79;
        dm   <= dmag[50:0];
        zero <= (den == 64'sd0);
        nsh[0] <= nm[0];
        nsh[1] <= nm[1];
        neg[0] <= num0[47] ^ den[63];
        neg[1] <= num1[47] ^ den[63];
        for (int l = 0; l < 2; l++) begin
          r[l]    <= 51'd0;
          q[l]    <= 47'd0;
          over[l] <= 1'b0;
        end
      end else if (busy) begin
        for (int l = 0; l < 2; l++) begin
          nsh[l] <= {nsh[l][46:0], 1'b0};
          r[l]   <= ge[l] ? rsub[l][50:0] : rs[l][50:0];
          if (cnt >= 7'd47) begin
            over[l] <= over[l] | ge[l];
          end else begin
            q[l] <= {q[l][45:0], ge[l]};
          end
        end
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 7'd1;
      end
    end
  end

  assign k0 = kv[0];
  assign k1 = kv[1];

endmodule
`default_nettype wire

### sv/tkf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tkf_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tkf_pkg::cmd_t      cmd,
  output tkf_pkg::sts_t           sts,
  input  wire tkf_pkg::cfg_t      cfg,
  input  wire logic signed [31:0] angle_meas,
  input  wire logic signed [31:0] gyro_rate,
  output logic signed [31:0]      angle_est,
  output logic signed [31:0]      rate_est,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  import tkf_pkg::*;

  logic signed [31:0] meas_r, gyro_r, angle_s, bias_s;
  logic signed [47:0] p00, p01, p10, p11, k0, k1;
  logic signed [32:0] err_r;
  logic signed [50:0] mul_a, mul_b, dt_op;
  logic signed [63:0] mul_res, den;
  logic signed [47:0] div_k0, div_k1;
  logic               mul_done, div_done;

  assign dt_op = 51'(signed'({1'b0, cfg.dt}));

  always_comb begin
    mul_b = dt_op;
    case (cmd.op)
      OP_ANGLE:     mul_a = 51'(gyro_r) - 51'(bias_s);
      OP_P00:       mul_a = 51'(signed'({1'b0, cfg.qa})) - 51'(p01) - 51'(p10);
      OP_P01P10:    mul_a = -51'(p11);
      OP_P11:       mul_a = 51'(signed'({1'b0, cfg.qg}));
      OP_C11: begin
        mul_a = 51'(k1);
        mul_b = 51'(p01);
      end
      OP_C10: begin
        mul_a = 51'(k1);
        mul_b = 51'(p00);
      end
      OP_C01: begin
        mul_a = 51'(k0);
        mul_b = 51'(p01);
      end
      OP_C00: begin
        mul_a = 51'(k0);
        mul_b = 51'(p00);
      end
      OP_ANG_CORR: begin
        mul_a = 51'(k0);
        mul_b = 51'(err_r);
      end
      OP_BIAS_CORR: begin
        mul_a = 51'(k1);
        mul_b = 51'(err_r);
      end
      default:      mul_a = 51'sd0;
    endcase
  end

  assign den = (64'(signed'({1'b0, cfg.r})) <<< 16) + 64'(p00);

  tkf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  tkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .den   (den),
    .num0  (p00),
    .num1  (p10),
    .done  (div_done),
    .k0    (div_k0),
    .k1    (div_k1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_s   <= 32'sd0;
      bias_s    <= 32'sd0;
      p00       <= ONE_Q32;
      p01       <= 48'sd0;
      p10       <= 48'sd0;
      p11       <= ONE_Q32;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        meas_r <= angle_meas;
        gyro_r <= gyro_rate;
      end
      if (cmd.div_start) begin
        err_r <= 33'(meas_r) - 33'(angle_s);
      end
      if (cmd.div_wb) begin
        k0 <= div_k0;
        k1 <= div_k1;
      end
      if (cmd.mul_wb) begin
        case (cmd.op)
          OP_ANGLE:     angle_s <= sat32(64'(angle_s) + mul_res);
          OP_P00:       p00 <= sat48(64'(p00) + mul_res);
          OP_P01P10: begin
            p01 <= sat48(64'(p01) + mul_res);
            p10 <= sat48(64'(p10) + mul_res);
          end
          OP_P11:       p11 <= sat48(64'(p11) + mul_res);
          OP_C11:       p11 <= sat48(64'(p11) - mul_res);
          OP_C10:       p10 <= sat48(64'(p10) - mul_res);
          OP_C01:       p01 <= sat48(64'(p01) - mul_res);
          OP_C00:       p00 <= sat48(64'(p00) - mul_res);
          OP_ANG_CORR:  angle_s <= sat32(64'(angle_s) + mul_res);
          OP_BIAS_CORR: bias_s <= sat32(64'(bias_s) + mul_res);
          default: begin
          end
        endcase
      end
      if (cmd.out_load) begin
        angle_est <= angle_s;
        rate_est  <= sat32(64'(gyro_r) - 64'(bias_s));
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.out_full = out_valid;

endmodule
`default_nettype wire

### sv/tkf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tkf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tkf_pkg::sts_t sts,
  output tkf_pkg::cmd_t      cmd
);
  import tkf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MUL_GO   = 6'b000010,
    S_MUL_WAIT = 6'b000100,
    S_DIV_GO   = 6'b001000,
    S_DIV_WAIT = 6'b010000,
    S_OUT      = 6'b100000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;

  always_comb begin
    state_next    = state;
    op_next       = op;
    cmd.load      = 1'b0;
    cmd.mul_start = 1'b0;
    cmd.mul_wb    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_wb    = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.op        = op;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          op_next    = OP_ANGLE;
          state_next = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (sts.mul_done) begin
          cmd.mul_wb = 1'b1;
          unique case (op)
            OP_P11:       state_next = S_DIV_GO;
            OP_BIAS_CORR: state_next = S_OUT;
            default: begin
              op_next    = op_t'(op + 4'd1);
              state_next = S_MUL_GO;
            end
          endcase
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_wb = 1'b1;
          op_next    = OP_C11;
          state_next = S_MUL_GO;
        end
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_ANGLE;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> state == S_MUL_WAIT)
    else $error("multiplier finished outside its wait state");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_full)
    else $error("result loaded over an untaken beat");

  a_accept_go: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL_GO && op == OP_ANGLE))
    else $error("accepted beat did not start the prediction");

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tkf_pkg::*;

  typedef struct {
    logic [31:0] angle;
    logic [31:0] rate;
  } est_t;

  class tilt_scoreboard;
    logic [31:0] qa, qg, r_noise, dt;
    longint angle_q, bias_q;
    longint p[4];
    est_t estimates[$];
    int unsigned noted, checked;

    function new();
      qa = QA_RESET;
      qg = QG_RESET;
      r_noise = R_RESET;
      dt = DT_RESET;
      angle_q = 0;
      bias_q = 0;
      p[0] = 64'sd1 <<< 32;
      p[1] = 0;
      p[2] = 0;
      p[3] = 64'sd1 <<< 32;
    endfunction

    function longint clamp(longint v, int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint mulq(longint a, longint b);
      logic [127:0] prod;
      logic [63:0] ma, mb, m;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      prod = ({64'd0, ma} * {64'd0, mb}) >> 32;
      m = (prod > (128'd1 << 62)) ? (64'd1 << 62) : prod[63:0];
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint divq(longint num, longint den);
      logic [127:0] quo;
      logic [63:0] nm, dm, q;
      if (den == 0) return 0;
      nm = num < 0 ? -num : num;
      dm = den < 0 ? -den : den;
      quo = ({64'd0, nm} << 32) / {64'd0, dm};
      q = (quo >= (128'd1 << 47)) ? (64'd1 << 47) : quo[63:0];
      return clamp(((num < 0) != (den < 0)) ? -longint'(q) : longint'(q), 48);
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_QA: qa = v;
        REG_QG: qg = v;
        REG_R: r_noise = v;
        REG_DT: dt = v;
      endcase
    endfunction

    function void note_sample(logic signed [31:0] meas_in, logic signed [31:0] gyro_in);
      longint meas, gyro, step, pd0, err, e, k0, k1, t0, t1, rate;
      longint p00, p01, p10, p11;
      est_t est;
      meas = meas_in;
      gyro = gyro_in;
      step = longint'({32'd0, dt});
      p00 = p[0];
      p01 = p[1];
      p10 = p[2];
      p11 = p[3];
      angle_q = clamp(angle_q + mulq(gyro - bias_q, step), 32);
      pd0 = longint'({32'd0, qa}) - p01 - p10;
      p00 = clamp(p00 + mulq(pd0, step), 48);
      p01 = clamp(p01 + mulq(-p11, step), 48);
      p10 = clamp(p10 + mulq(-p11, step), 48);
      p11 = clamp(p11 + mulq(longint'({32'd0, qg}), step), 48);
      err = meas - angle_q;
      e = (longint'({32'd0, r_noise}) <<< 16) + p00;
      k0 = divq(p00, e);
      k1 = divq(p10, e);
      t0 = p00;
      t1 = p01;
      p[0] = clamp(p00 - mulq(k0, t0), 48);
      p[1] = clamp(p01 - mulq(k0, t1), 48);
      p[2] = clamp(p10 - mulq(k1, t0), 48);
      p[3] = clamp(p11 - mulq(k1, t1), 48);
      angle_q = clamp(angle_q + mulq(k0, err), 32);
      bias_q = clamp(bias_q + mulq(k1, err), 32);
      rate = clamp(gyro - bias_q, 32);
      est.angle = angle_q[31:0];
      est.rate = rate[31:0];
      estimates.push_back(est);
      noted++;
    endfunction

    function bit check_estimate(logic [31:0] a, logic [31:0] rt, output string msg);
      est_t want;
      checked++;
      if (estimates.size() == 0) begin
        msg = $sformatf("result beat with nothing outstanding: angle %h rate %h", a, rt);
        return 0;
      end
      want = estimates.pop_front();
      if (a !== want.angle || rt !== want.rate) begin
        msg = $sformatf("result %0d: angle %h (want %h) rate %h (want %h)",
                        checked, a, want.angle, rt, want.rate);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] angle_meas = '0;
  logic signed [31:0] gyro_rate = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] angle_est, rate_est;

  int unsigned in_idle_pct = 18, out_idle_pct = 66;
  int unsigned errors = 0;
  int unsigned reg_writes = 0;
  tilt_scoreboard sb = new();

  tilt_kalman_filter i_dut (.*);

  always #2 clk = ~clk;

  task automatic report(string msg);
    $display("tb_top: mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    string msg;
    if (!rst && in_valid && in_ready) sb.note_sample(angle_meas, gyro_rate);
    if (!rst && out_valid && out_ready) begin
      if (!sb.check_estimate(angle_est, rate_est, msg)) report(msg);
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {idx, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    sb.write_reg(idx, v);
    reg_writes++;
  endtask

  task automatic send(logic [31:0] meas, logic [31:0] gyro);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    angle_meas = meas;
    gyro_rate = gyro;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.estimates.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] a, logic [31:0] g, logic [31:0] rn, logic [31:0] d);
    write_reg(REG_QA, a);
    write_reg(REG_QG, g);
    write_reg(REG_R, rn);
    write_reg(REG_DT, d);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return $urandom_range(65535) - 32768;
      default: return $urandom_range(11796480) - 5898240;
    endcase
  endfunction

  function automatic logic [31:0] rand_noise();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 0;
      2: return 32'hffff_ffff;
      default: return $urandom_range(50000000);
    endcase
  endfunction

  task automatic random_block(int n);
    logic [31:0] base;
    base = rand_field();
    repeat (n) begin
      if ($urandom_range(3) == 0) send(rand_field(), rand_field());
      else send(base + $urandom_range(1310720) - 655360, $urandom_range(6553600) - 3276800);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send(0, 0);
    send(32'h7fff_ffff, 32'h7fff_ffff);
    send(32'h8000_0000, 32'h8000_0000);
    send(32'h7fff_ffff, 32'h8000_0000);
    send(32'h8000_0000, 32'h7fff_ffff);
    send(32'h0000_0001, 32'hffff_ffff);
    send(32'h0005_a000, 32'h0001_0000);
    drain();
    // Zero noise and zero step drive the angle variance to nothing, so the
    // following beats see a zero divisor and zero gains.
    set_all(0, 0, 0, 0);
    send(32'h0010_0000, 32'h0002_0000);
    send(32'hfff0_0000, 32'hfffe_0000);
    send(32'h1234_5678, 32'h8765_4321);
    drain();
    set_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(32'h7fff_ffff, 32'h7fff_ffff);
    send(32'h8000_0000, 32'h8000_0000);
    send(32'h0001_0000, 32'hffff_0000);
    send(0, 0);
    drain();
    set_all(0, 32'hffff_ffff, 0, 32'hffff_ffff);
    send(32'h4000_0000, 32'hc000_0000);
    send(32'h0100_0000, 32'h0100_0000);
    send(32'hc000_0000, 32'h4000_0000);
    drain();
    for (int blk = 0; blk < 9; blk++) begin
      if (blk == 3) begin
        in_idle_pct = 66;
        out_idle_pct = 18;
      end else if (blk == 6) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (blk % 3 == 0) set_all(QA_RESET, QG_RESET, R_RESET, DT_RESET);
      else set_all(rand_noise(), rand_noise(), rand_noise(), rand_noise());
      random_block(130);
      drain();
    end
    $display("tb_top: %0d input beats and %0d result beats checked", sb.noted, sb.checked);
    $display("tb_top: %0d register writes over default, zero, full-scale and random settings",
             reg_writes);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("tb_top: timeout");
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
